>>> hdl/srtf_pkg.sv
`timescale 1ns / 1ps

package srtf_pkg;

    // Table size and derived widths
    localparam int MAX_PROCS = 16;
    localparam int SLOT_W    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int COUNT_W   = $clog2(MAX_PROCS + 1);
    localparam int TIME_W    = 24;

    // Action codes
    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Status codes
    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_IDLE     = 3'd2;
    localparam logic [2:0] ST_RAN      = 3'd3;
    localparam logic [2:0] ST_FINISHED = 3'd4;
    localparam logic [2:0] ST_CLEARED  = 3'd5;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] arrival_time;
        logic [11:0] burst_length;
    } t_in_word;

    typedef struct packed {
        logic [2:0]        status;
        logic [3:0]        slot;
        logic [TIME_W-1:0] completion_time;
        logic [TIME_W-1:0] turnaround_time;
        logic [TIME_W-1:0] waiting_time;
        logic [TIME_W-1:0] response_time;
        logic              all_done;
    } t_out_word;

    // One table entry as held in the slot RAM
    typedef struct packed {
        logic [15:0]       arrival;
        logic [11:0]       burst;
        logic [11:0]       remaining;
        logic [TIME_W-1:0] first_run;
    } t_slot_word;

    localparam int SLOT_WORD_W = $bits(t_slot_word);

endpackage

>>> hdl/srtf_ram.sv
`timescale 1ns / 1ps

module srtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/srtf_scheduler.sv
// Add and clear: one word out the cycle after start, busy stays low.
// Tick: scan reads one slot per cycle, then fetch and update the chosen slot, and a
//   finishing slot takes a further state to report; an idle tick ends after the scan.
//   busy is high for the whole tick.
// Results are strobed on o_valid for one cycle; the receiver cannot stall.
// Synchronous active-low reset empties the table and zeroes the time; no RAM sweep.
`timescale 1ns / 1ps

module srtf_scheduler (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  srtf_pkg::t_in_word  i_in,
    output logic                busy,
    output logic                o_valid,
    output srtf_pkg::t_out_word o_res
);

    import srtf_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_FETCH  = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    // Control state
    logic [2:0]           r_state, n_state;
    logic [COUNT_W-1:0]   r_pc, n_pc;
    logic [COUNT_W-1:0]   r_fin, n_fin;
    logic [TIME_W-1:0]    r_time, n_time;
    logic [MAX_PROCS-1:0] r_started, n_started;
    logic [COUNT_W-1:0]   r_idx, n_idx;
    logic                 r_cmp_vld, n_cmp_vld;
    logic                 r_found, n_found;
    logic                 r_valid, n_valid;

    // Datapath registers
    logic [SLOT_W-1:0]    r_best, n_best;
    logic [11:0]          r_best_rem, n_best_rem;
    logic [15:0]          r_arr, n_arr;
    logic [TIME_W-1:0]    r_ab, n_ab;
    logic [TIME_W-1:0]    r_rsp, n_rsp;
    t_out_word            r_out, n_out;

    // Slot RAM port signals
    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    t_slot_word           ram_wdata;
    logic [SLOT_W-1:0]    ram_raddr;
    logic [SLOT_WORD_W-1:0] ram_rdata;
    t_slot_word           rd;

    logic                 accept;
    logic                 issue;
    logic                 cand;
    logic [11:0]          bl_fix;
    logic [11:0]          rem_dec;

    srtf_ram #(
        .WIDTH (SLOT_WORD_W),
        .DEPTH (MAX_PROCS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd      = t_slot_word'(ram_rdata);
    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign issue   = (r_state == S_SCAN) && (r_idx != r_pc);
    assign bl_fix  = (i_in.burst_length == 12'd0) ? 12'd1 : i_in.burst_length;
    assign rem_dec = rd.remaining - 12'd1;
    // Ready candidate: arrived and still has work
    assign cand    = ({8'd0, rd.arrival} <= r_time) && (rd.remaining != 12'd0);

    // Sequencer and datapath next state
    always_comb begin
        n_state    = r_state;
        n_pc       = r_pc;
        n_fin      = r_fin;
        n_time     = r_time;
        n_started  = r_started;
        n_idx      = r_idx;
        n_cmp_vld  = issue;
        n_found    = r_found;
        n_valid    = 1'b0;
        n_best     = r_best;
        n_best_rem = r_best_rem;
        n_arr      = r_arr;
        n_ab       = r_ab;
        n_rsp      = r_rsp;
        n_out      = r_out;
        ram_we     = 1'b0;
        ram_waddr  = r_best;
        ram_wdata  = rd;
        ram_raddr  = r_best;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out = '0;
                    unique case (i_in.action)
                        ACT_ADD: begin
                            n_valid = 1'b1;
                            if (r_pc == COUNT_W'(MAX_PROCS)) begin
                                n_out.status   = ST_FULL;
                                n_out.all_done = (r_fin == r_pc);
                            end else begin
                                ram_we              = 1'b1;
                                ram_waddr           = r_pc[SLOT_W-1:0];
                                ram_wdata.arrival   = i_in.arrival_time;
                                ram_wdata.burst     = bl_fix;
                                ram_wdata.remaining = bl_fix;
                                ram_wdata.first_run = '0;
                                n_started[r_pc[SLOT_W-1:0]] = 1'b0;
                                n_pc           = r_pc + COUNT_W'(1);
                                n_out.status   = ST_ADDED;
                                n_out.slot     = 4'(r_pc[SLOT_W-1:0]);
                                n_out.all_done = 1'b0;
                            end
                        end
                        ACT_TICK: begin
                            n_state = S_SCAN;
                            n_idx   = '0;
                            n_found = 1'b0;
                        end
                        ACT_CLEAR: begin
                            n_valid        = 1'b1;
                            n_pc           = '0;
                            n_fin          = '0;
                            n_time         = '0;
                            n_started      = '0;
                            n_out.status   = ST_CLEARED;
                            n_out.all_done = 1'b1;
                        end
                        default: begin
                            n_out = r_out;
                        end
                    endcase
                end
            end

            // One slot read per cycle, compared in the cycle after its read
            S_SCAN: begin
                ram_raddr = r_idx[SLOT_W-1:0];
                if (issue) begin
                    n_idx = r_idx + COUNT_W'(1);
                end
                if (r_cmp_vld && cand && (!r_found || rd.remaining < r_best_rem)) begin
                    n_found    = 1'b1;
                    n_best     = r_idx[SLOT_W-1:0] - SLOT_W'(1);
                    n_best_rem = rd.remaining;
                end
                if (!issue && !r_cmp_vld) begin
                    if (r_found) begin
                        n_state = S_FETCH;
                    end else begin
                        n_state        = S_IDLE;
                        n_valid        = 1'b1;
                        n_time         = r_time + TIME_W'(1);
                        n_out          = '0;
                        n_out.status   = ST_IDLE;
                        n_out.all_done = (r_fin == r_pc);
                    end
                end
            end

            S_FETCH: begin
                n_state = S_UPDATE;
            end

            // Run the chosen slot for one unit and write it back
            S_UPDATE: begin
                ram_we              = 1'b1;
                ram_wdata.remaining = rem_dec;
                if (!r_started[r_best]) begin
                    ram_wdata.first_run = r_time;
                end
                n_started[r_best] = 1'b1;
                n_time = r_time + TIME_W'(1);
                n_arr  = rd.arrival;
                n_ab   = TIME_W'(rd.arrival) + TIME_W'(rd.burst);
                n_rsp  = ram_wdata.first_run - TIME_W'(rd.arrival);
                n_out      = '0;
                n_out.slot = 4'(r_best);
                if (rem_dec == 12'd0) begin
                    n_state = S_FIN;
                end else begin
                    n_state        = S_IDLE;
                    n_valid        = 1'b1;
                    n_out.status   = ST_RAN;
                    n_out.all_done = (r_fin == r_pc);
                end
            end

            // Completion figures from the advanced time
            S_FIN: begin
                n_state               = S_IDLE;
                n_valid               = 1'b1;
                n_fin                 = r_fin + COUNT_W'(1);
                n_out.status          = ST_FINISHED;
                n_out.completion_time = r_time;
                n_out.turnaround_time = r_time - TIME_W'(r_arr);
                n_out.waiting_time    = r_time - r_ab;
                n_out.response_time   = r_rsp;
                n_out.all_done        = ((r_fin + COUNT_W'(1)) == r_pc);
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pc      <= '0;
            r_fin     <= '0;
            r_time    <= '0;
            r_started <= '0;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pc      <= n_pc;
            r_fin     <= n_fin;
            r_time    <= n_time;
            r_started <= n_started;
            r_idx     <= n_idx;
            r_cmp_vld <= n_cmp_vld;
            r_found   <= n_found;
            r_valid   <= n_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_best     <= n_best;
        r_best_rem <= n_best_rem;
        r_arr      <= n_arr;
        r_ab       <= n_ab;
        r_rsp      <= n_rsp;
        r_out      <= n_out;
    end

    assign o_valid = r_valid;
    assign o_res   = r_out;

    // Checks
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_in.action == ACT_TICK) |=> busy)
        else $error("tick accepted but block not busy");

    a_fin_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin <= r_pc)
        else $error("finished count above process count");

    a_best_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |-> r_found && (COUNT_W'(r_best) < r_pc))
        else $error("chosen slot outside table");

    a_fin_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_res.status == ST_FINISHED) |-> o_res.completion_time == r_time)
        else $error("completion time differs from current time");

endmodule
